/* sv/nfps_pkg.sv */
package nfps_pkg;

	localparam int MAX_BANKS   = 2;
	localparam int MAX_BLOCKS  = 16;
	localparam int MAX_PAGES   = 16;
	localparam int DATA_WORDS  = 8;
	localparam int SPARE_WORDS = 2;

	localparam int PAGE_WORDS  = DATA_WORDS + SPARE_WORDS;
	localparam int MARK_ROWS   = MAX_BANKS * MAX_BLOCKS;
	localparam int ROW_W       = $clog2(MARK_ROWS);
	localparam int PG_W        = $clog2(MAX_PAGES);
	localparam int STORE_DEPTH = MARK_ROWS * MAX_PAGES * PAGE_WORDS;
	localparam int ADDR_W      = $clog2(STORE_DEPTH);
	localparam int CNT_W       = $clog2(PAGE_WORDS + 1);
	localparam int IDX_W       = $clog2(PAGE_WORDS);

	localparam int OP_W    = 2;
	localparam int BANK_W  = 2;
	localparam int BLOCK_W = 5;
	localparam int PAGE_W  = 5;
	localparam int WIDX_W  = 4;
	localparam int WORD_W  = 32;
	localparam int STAT_W  = 3;
	localparam int NB_W    = 2;
	localparam int NK_W    = 5;
	localparam int NP_W    = 5;

	localparam int IN_DATA_W  = 48;
	localparam int OUT_DATA_W = 40;

	typedef enum logic [OP_W-1:0] {
		OP_LOAD    = 2'd0,
		OP_PROGRAM = 2'd1,
		OP_READ    = 2'd2,
		OP_ERASE   = 2'd3
	} op_t;

	typedef enum logic [STAT_W-1:0] {
		ST_OK        = 3'd0,
		ST_INVALID   = 3'd1,
		ST_OVERWRITE = 3'd2,
		ST_POSITION  = 3'd3,
		ST_EMPTY     = 3'd4
	} status_t;

	localparam logic [1:0] REG_NUM_BANKS  = 2'd0;
	localparam logic [1:0] REG_NUM_BLOCKS = 2'd1;
	localparam logic [1:0] REG_NUM_PAGES  = 2'd2;

	typedef struct packed {
		logic [NB_W-1:0] nb;
		logic [NK_W-1:0] nk;
		logic [NP_W-1:0] np;
	} cfg_t;

	typedef struct packed {
		logic [OP_W-1:0]    op;
		logic [BANK_W-1:0]  bank;
		logic [BLOCK_W-1:0] block;
		logic [PAGE_W-1:0]  page;
		logic [WIDX_W-1:0]  widx;
		logic [WORD_W-1:0]  wval;
	} item_t;

	typedef struct packed {
		logic accept;
		logic stat_ld;
		logic mark_set;
		logic mark_clr;
		logic base_ld;
		logic prog_wr;
		logic read_run;
		logic resp_ld;
	} cmd_t;

	typedef struct packed {
		op_t     op;
		status_t chk;
		logic    prog_last;
		logic    read_done;
		logic    out_free;
	} sts_t;

endpackage

/* sv/nand_flash_page_store.sv */
// nand flash page store
// input stream s_*: one beat per item, operation in s_tuser[1:0], address and
// load word in s_tdata. loads fill the page buffer; program copies it to a
// page; read returns the page; erase clears a block's marks below the page count.
// output stream m_*: status, read word and index in m_tdata, m_tlast on the
// final beat of each item. every item but a load yields one beat; a read of
// a written page yields ten beats, one per page word.
// flow: loads stream back to back. program runs check, ten store writes and
// response; a read runs check and ten store reads issued one per cycle, while
// the output is free, through the single store port with a registered read;
// erase and errors run check and response. s_tready is high only between
// items; an item is taken while the previous result beat still waits.
// a stalled receiver holds the output register and the read pipeline; no beat
// is lost. reset clears written marks and page buffer and sets the size
// registers to 2 banks, 16 blocks, 16 pages; no clearing pass, the store is
// gated by the marks. size registers are written over apb at 0x0, 0x4, 0x8.
module nand_flash_page_store (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	// bank, block, page, word_index, word_value
	input  logic [47:0] s_tdata,
	// operation
	input  logic [1:0]  s_tuser,
	output logic        m_tvalid,
	input  logic        m_tready,
	// status, read_word, read_index, zero pad
	output logic [39:0] m_tdata,
	output logic        m_tlast,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [3:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);
	import nfps_pkg::*;

	cfg_t        cfg_q;
	item_t       in_item;
	cmd_t        cmd;
	sts_t        sts;
	logic [1:0]  reg_idx;
	logic        cfg_wr;

	assign pready  = 1'b1;
	assign reg_idx = paddr[3:2];
	assign cfg_wr  = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.nb <= NB_W'(2);
			cfg_q.nk <= NK_W'(16);
			cfg_q.np <= NP_W'(16);
		end else if (cfg_wr) begin
			case (reg_idx)
				REG_NUM_BANKS:  cfg_q.nb <= pwdata[NB_W-1:0];
				REG_NUM_BLOCKS: cfg_q.nk <= pwdata[NK_W-1:0];
				REG_NUM_PAGES:  cfg_q.np <= pwdata[NP_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (reg_idx)
			REG_NUM_BANKS:  prdata = 32'(cfg_q.nb);
			REG_NUM_BLOCKS: prdata = 32'(cfg_q.nk);
			REG_NUM_PAGES:  prdata = 32'(cfg_q.np);
			default:        prdata = '0;
		endcase
	end

	assign in_item.op    = s_tuser;
	assign in_item.bank  = s_tdata[1:0];
	assign in_item.block = s_tdata[6:2];
	assign in_item.page  = s_tdata[11:7];
	assign in_item.widx  = s_tdata[15:12];
	assign in_item.wval  = s_tdata[47:16];

	nfps_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.in_op    (s_tuser),
		.sts      (sts),
		.cmd      (cmd)
	);

	nfps_dp u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg      (cfg_q),
		.in_item  (in_item),
		.cmd      (cmd),
		.sts      (sts),
		.m_tready (m_tready),
		.m_tvalid (m_tvalid),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast)
	);

endmodule

/* sv/nfps_ctrl.sv */
module nfps_ctrl (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      s_tvalid,
	output logic                      s_tready,
	input  logic [nfps_pkg::OP_W-1:0] in_op,
	input  nfps_pkg::sts_t            sts,
	output nfps_pkg::cmd_t            cmd
);
	import nfps_pkg::*;

	typedef enum logic [4:0] {
		S_IDLE  = 5'b00001,
		S_CHECK = 5'b00010,
		S_PROG  = 5'b00100,
		S_READ  = 5'b01000,
		S_RESP  = 5'b10000
	} state_t;

	state_t state_q, state_nxt;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

	assign s_tready = (state_q == S_IDLE);

	always_comb begin
		cmd = '0;
		state_nxt = state_q;
		case (state_q)
			S_IDLE: begin
				if (s_tvalid) begin
					cmd.accept = 1'b1;
					// loads finish in the accept cycle
					if (in_op != OP_LOAD) state_nxt = S_CHECK;
				end
			end
			S_CHECK: begin
				cmd.stat_ld = 1'b1;
				state_nxt = S_RESP;
				if (sts.chk == ST_OK) begin
					case (sts.op)
						OP_PROGRAM: begin
							cmd.mark_set = 1'b1;
							cmd.base_ld = 1'b1;
							state_nxt = S_PROG;
						end
						OP_READ: begin
							cmd.base_ld = 1'b1;
							state_nxt = S_READ;
						end
						OP_ERASE: begin
							cmd.mark_clr = 1'b1;
						end
						default: begin
							state_nxt = S_RESP;
						end
					endcase
				end
			end
			S_PROG: begin
				cmd.prog_wr = 1'b1;
				if (sts.prog_last) state_nxt = S_RESP;
			end
			S_READ: begin
				cmd.read_run = 1'b1;
				if (sts.read_done) state_nxt = S_IDLE;
			end
			S_RESP: begin
				if (sts.out_free) begin
					cmd.resp_ld = 1'b1;
					state_nxt = S_IDLE;
				end
			end
			default: begin
				state_nxt = S_IDLE;
			end
		endcase
	end

endmodule

/* sv/nfps_dp.sv */
module nfps_dp (
	input  logic                            clk,
	input  logic                            arst_n,
	input  nfps_pkg::cfg_t                  cfg,
	input  nfps_pkg::item_t                 in_item,
	input  nfps_pkg::cmd_t                  cmd,
	output nfps_pkg::sts_t                  sts,
	input  logic                            m_tready,
	output logic                            m_tvalid,
	output logic [nfps_pkg::OUT_DATA_W-1:0] m_tdata,
	output logic                            m_tlast
);
	import nfps_pkg::*;

	item_t               item_q;
	logic [WORD_W-1:0]   buf_q [PAGE_WORDS];
	logic [MAX_PAGES-1:0] mark_q [MARK_ROWS];
	logic [WORD_W-1:0]   store_mem [STORE_DEPTH];
	logic [ADDR_W-1:0]   base_q;
	logic [CNT_W-1:0]    cnt_q;
	status_t             stat_q;

	logic [WORD_W-1:0]   rd_s1;
	logic [IDX_W-1:0]    idx_s1;
	logic                v_s1;

	logic                out_v_q;
	status_t             out_stat_q;
	logic [WORD_W-1:0]   out_word_q;
	logic [IDX_W-1:0]    out_idx_q;
	logic                out_last_q;

	logic [NB_W-1:0]      nb_eff;
	logic [NK_W-1:0]      nk_eff;
	logic [NP_W-1:0]      np_eff;
	logic                 invalid;
	logic [ROW_W-1:0]     row;
	logic [MAX_PAGES-1:0] row_bits;
	logic [MAX_PAGES-1:0] pmask;
	logic [PG_W-1:0]      pg;
	logic                 cur;
	logic                 prev;
	logic                 any;
	status_t              chk;
	logic [ADDR_W-1:0]    addr;
	logic                 out_free;
	logic                 move;
	logic                 rd_issue;

	// size registers above the maximum count as the maximum
	assign nb_eff = (32'(cfg.nb) > MAX_BANKS)  ? NB_W'(MAX_BANKS)  : cfg.nb;
	assign nk_eff = (32'(cfg.nk) > MAX_BLOCKS) ? NK_W'(MAX_BLOCKS) : cfg.nk;
	assign np_eff = (32'(cfg.np) > MAX_PAGES)  ? NP_W'(MAX_PAGES)  : cfg.np;

	assign invalid = (item_q.bank >= nb_eff) || (item_q.block >= nk_eff) ||
	                 ((op_t'(item_q.op) != OP_ERASE) && (item_q.page >= np_eff));

	assign row = invalid ? '0 :
	             ROW_W'(32'(item_q.bank) * MAX_BLOCKS + 32'(item_q.block));
	assign row_bits = mark_q[row];
	assign pg = item_q.page[PG_W-1:0];
	assign cur = row_bits[pg];
	assign prev = (pg == '0) ? 1'b1 : row_bits[pg - PG_W'(1)];

	always_comb begin
		for (int j = 0; j < MAX_PAGES; j++) begin
			pmask[j] = (j < 32'(np_eff));
		end
	end

	assign any = |(row_bits & pmask);

	always_comb begin
		chk = ST_OK;
		if (invalid) begin
			chk = ST_INVALID;
		end else begin
			case (op_t'(item_q.op))
				OP_PROGRAM: chk = cur ? ST_OVERWRITE : (prev ? ST_OK : ST_POSITION);
				OP_READ:    chk = cur ? ST_OK : ST_EMPTY;
				OP_ERASE:   chk = any ? ST_OK : ST_EMPTY;
				default:    chk = ST_OK;
			endcase
		end
	end

	assign addr     = base_q + ADDR_W'(cnt_q);
	assign out_free = !out_v_q || m_tready;
	assign move     = v_s1 && out_free;
	assign rd_issue = cmd.read_run && (cnt_q != CNT_W'(PAGE_WORDS)) && (!v_s1 || move);

	assign sts.op        = op_t'(item_q.op);
	assign sts.chk       = chk;
	assign sts.prog_last = (cnt_q == CNT_W'(PAGE_WORDS - 1));
	assign sts.read_done = (cnt_q == CNT_W'(PAGE_WORDS)) && !v_s1;
	assign sts.out_free  = out_free;

	always_ff @(posedge clk) begin
		if (cmd.accept) item_q <= in_item;
		if (cmd.stat_ld) stat_q <= chk;
		if (cmd.base_ld) base_q <= ADDR_W'((32'(row) * MAX_PAGES + 32'(pg)) * PAGE_WORDS);
		if (rd_issue) idx_s1 <= cnt_q[IDX_W-1:0];
	end

	// page store, one port
	always_ff @(posedge clk) begin
		if (cmd.prog_wr) store_mem[addr] <= buf_q[cnt_q[IDX_W-1:0]];
		if (rd_issue) rd_s1 <= store_mem[addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < PAGE_WORDS; i++) buf_q[i] <= '0;
			for (int r = 0; r < MARK_ROWS; r++) mark_q[r] <= '0;
			cnt_q <= '0;
			v_s1 <= 1'b0;
		end else begin
			if (cmd.accept && (op_t'(in_item.op) == OP_LOAD) &&
			    (32'(in_item.widx) < PAGE_WORDS)) begin
				buf_q[in_item.widx[IDX_W-1:0]] <= in_item.wval;
			end
			if (cmd.mark_set) mark_q[row] <= row_bits | (MAX_PAGES'(1) << pg);
			else if (cmd.mark_clr) mark_q[row] <= row_bits & ~pmask;
			if (cmd.base_ld) cnt_q <= '0;
			else if (cmd.prog_wr || rd_issue) cnt_q <= cnt_q + CNT_W'(1);
			if (rd_issue) v_s1 <= 1'b1;
			else if (move) v_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q <= 1'b0;
		end else if (move || cmd.resp_ld) begin
			out_v_q <= 1'b1;
		end else if (m_tready) begin
			out_v_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (move) begin
			out_stat_q <= ST_OK;
			out_word_q <= rd_s1;
			out_idx_q  <= idx_s1;
			out_last_q <= (idx_s1 == IDX_W'(PAGE_WORDS - 1));
		end else if (cmd.resp_ld) begin
			out_stat_q <= stat_q;
			out_word_q <= '0;
			out_idx_q  <= '0;
			out_last_q <= 1'b1;
		end
	end

	assign m_tvalid = out_v_q;
	assign m_tlast  = out_last_q;
	assign m_tdata  = OUT_DATA_W'({out_idx_q, out_word_q, out_stat_q});

`ifndef ASSERT_OFF
	a_cnt_range: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CNT_W'(PAGE_WORDS))
		else $error("word counter past page end");
	a_mark_set: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.mark_set |=> cur)
		else $error("programmed page not marked");
	a_erase_clr: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.mark_clr |=> !any)
		else $error("erased block still has marks");
	a_port_excl: assert property (@(posedge clk) disable iff (!arst_n)
		!(cmd.prog_wr && rd_issue))
		else $error("store written and read together");
	a_mid_run: assert property (@(posedge clk) disable iff (!arst_n)
		(out_v_q && !out_last_q) |-> (out_stat_q == ST_OK &&
		out_idx_q != IDX_W'(PAGE_WORDS - 1)))
		else $error("non-final beat malformed");
`endif

endmodule

/* tb/testbench.sv */
`timescale 1ns / 100ps

module testbench;
	import nfps_pkg::*;

	localparam int PAGE_SLOTS  = MARK_ROWS * MAX_PAGES;
	localparam int CYCLE_LIMIT = 600000;
	localparam int SETTLE_CYC  = 20;

	typedef struct packed {
		logic [2:0]  status;
		logic [31:0] word;
		logic [3:0]  idx;
		logic        last;
	} beat_t;

	typedef struct packed {
		item_t      it;
		logic       typed;
		logic [2:0] st;
	} step_t;

	logic        clk;
	logic        arst_n;
	logic        s_tvalid;
	logic        s_tready;
	logic [47:0] s_tdata;
	logic [1:0]  s_tuser;
	logic        m_tvalid;
	logic        m_tready;
	logic [39:0] m_tdata;
	logic        m_tlast;
	logic        psel;
	logic        penable;
	logic        pwrite;
	logic [3:0]  paddr;
	logic [31:0] pwdata;
	logic [31:0] prdata;
	logic        pready;

	// flash image as the block should hold it
	logic [31:0] load_buf [PAGE_WORDS];
	logic [31:0] flash_words [PAGE_SLOTS][PAGE_WORDS];
	bit          page_written [PAGE_SLOTS];
	int          cfg_banks;
	int          cfg_blocks;
	int          cfg_pages;

	beat_t beats_due [$];
	int    mismatches;
	int    beats_seen;
	int    items_sent;
	int    phases_run;
	int    cycles;
	int    hold_len;
	bit    quiet;

	nand_flash_page_store u_top (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast),
		.psel     (psel),
		.penable  (penable),
		.pwrite   (pwrite),
		.paddr    (paddr),
		.pwdata   (pwdata),
		.prdata   (prdata),
		.pready   (pready)
	);

	initial clk = 1'b0;
	always #2 clk = ~clk;

	function automatic item_t mk(input logic [1:0] op, input int bank, input int blk,
			input int pg, input int widx, input logic [31:0] wval);
		item_t it;
		it.op    = op;
		it.bank  = bank[1:0];
		it.block = blk[4:0];
		it.page  = pg[4:0];
		it.widx  = widx[3:0];
		it.wval  = wval;
		return it;
	endfunction

	function automatic step_t plan_row(input item_t it, input bit typed, input logic [2:0] st);
		step_t s;
		s.it    = it;
		s.typed = typed;
		s.st    = st;
		return s;
	endfunction

	// expected beats of one item; updates the flash image
	function automatic void flash_predict(input item_t it, ref beat_t res[$]);
		int nb, nk, np, slot, base, i, w;
		bit any_written;
		nb = (cfg_banks < MAX_BANKS) ? cfg_banks : MAX_BANKS;
		nk = (cfg_blocks < MAX_BLOCKS) ? cfg_blocks : MAX_BLOCKS;
		np = (cfg_pages < MAX_PAGES) ? cfg_pages : MAX_PAGES;
		res.delete();
		if (it.op == OP_LOAD) begin
			if (it.widx < PAGE_WORDS)
				load_buf[it.widx] = it.wval;
			return;
		end
		if (it.bank >= nb || it.block >= nk || (it.op != OP_ERASE && it.page >= np)) begin
			res.push_back({ST_INVALID, 32'd0, 4'd0, 1'b1});
			return;
		end
		slot = (it.bank * MAX_BLOCKS + it.block) * MAX_PAGES + it.page;
		base = (it.bank * MAX_BLOCKS + it.block) * MAX_PAGES;
		case (it.op)
			OP_PROGRAM: begin
				if (page_written[slot]) begin
					res.push_back({ST_OVERWRITE, 32'd0, 4'd0, 1'b1});
				end else if (it.page != 0 && !page_written[slot - 1]) begin
					res.push_back({ST_POSITION, 32'd0, 4'd0, 1'b1});
				end else begin
					page_written[slot] = 1'b1;
					for (i = 0; i < PAGE_WORDS; i++)
						flash_words[slot][i] = load_buf[i];
					res.push_back({ST_OK, 32'd0, 4'd0, 1'b1});
				end
			end
			OP_READ: begin
				if (!page_written[slot]) begin
					res.push_back({ST_EMPTY, 32'd0, 4'd0, 1'b1});
				end else begin
					for (i = 0; i < PAGE_WORDS; i++)
						res.push_back({ST_OK, flash_words[slot][i], i[3:0],
							i == PAGE_WORDS - 1});
				end
			end
			default: begin
				any_written = 1'b0;
				for (i = 0; i < np; i++)
					if (page_written[base + i])
						any_written = 1'b1;
				if (!any_written) begin
					res.push_back({ST_EMPTY, 32'd0, 4'd0, 1'b1});
				end else begin
					// only pages below the current page count are cleared
					for (i = 0; i < np; i++) begin
						page_written[base + i] = 1'b0;
						for (w = 0; w < PAGE_WORDS; w++)
							flash_words[base + i][w] = 32'd0;
					end
					res.push_back({ST_OK, 32'd0, 4'd0, 1'b1});
				end
			end
		endcase
	endfunction

	task automatic send_item(input item_t it, input bit typed, input logic [2:0] typed_st);
		beat_t res [$];
		if (!quiet && $urandom_range(0, 6) == 0) begin
			s_tvalid <= 1'b0;
			repeat ($urandom_range(1, 13)) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= {it.wval, it.widx, it.page, it.block, it.bank};
		s_tuser  <= it.op;
		do @(posedge clk); while (!s_tready);
		flash_predict(it, res);
		if (typed)
			beats_due.push_back({typed_st, 32'd0, 4'd0, 1'b1});
		else
			foreach (res[k])
				beats_due.push_back(res[k]);
		items_sent++;
	endtask

	// stop offering and wait for every expected beat
	task automatic drain(input int extra);
		s_tvalid <= 1'b0;
		do @(posedge clk); while (beats_due.size() != 0);
		repeat (extra) @(posedge clk);
	endtask

	task automatic write_reg(input logic [3:0] addr, input logic [31:0] val);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= addr;
		pwdata  <= val;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		@(posedge clk);
	endtask

	task automatic run_phase(input int nbk, input int nblk, input int npg, input int count,
			input int hold, input bit pause_mid);
		int nb, nk, np, done, sel, b, k, p, n, tries, slot;
		item_t it;
		done = 0;
		drain(SETTLE_CYC);
		write_reg({REG_NUM_BANKS, 2'b00}, nbk);
		write_reg({REG_NUM_BLOCKS, 2'b00}, nblk);
		write_reg({REG_NUM_PAGES, 2'b00}, npg);
		cfg_banks  = nbk & 3;
		cfg_blocks = nblk & 31;
		cfg_pages  = npg & 31;
		nb = (cfg_banks < MAX_BANKS) ? cfg_banks : MAX_BANKS;
		nk = (cfg_blocks < MAX_BLOCKS) ? cfg_blocks : MAX_BLOCKS;
		np = (cfg_pages < MAX_PAGES) ? cfg_pages : MAX_PAGES;
		hold_len = hold;
		phases_run++;
		while (done < count) begin
			if (pause_mid && done >= count / 2) begin
				drain(0);
				pause_mid = 1'b0;
			end
			sel = $urandom_range(0, 99);
			if (nb == 0 || nk == 0 || np == 0 || sel < 15) begin
				it = mk(2'($urandom_range(0, 3)), $urandom_range(0, 3),
					$urandom_range(0, 31), $urandom_range(0, 31), $urandom_range(0, 15),
					$urandom);
				send_item(it, 1'b0, ST_OK);
				done++;
			end else if (sel < 55) begin
				// fill some buffer words, then program the next free page
				b = $urandom_range(0, nb - 1);
				k = $urandom_range(0, nk - 1);
				repeat ($urandom_range(0, PAGE_WORDS)) begin
					send_item(mk(OP_LOAD, $urandom_range(0, 3), $urandom_range(0, 31),
						$urandom_range(0, 31), $urandom_range(0, PAGE_WORDS - 1),
						$urandom), 1'b0, ST_OK);
					done++;
				end
				p = -1;
				for (n = np - 1; n >= 0; n--)
					if (!page_written[(b * MAX_BLOCKS + k) * MAX_PAGES + n])
						p = n;
				if (p < 0 || $urandom_range(0, 9) == 0)
					p = $urandom_range(0, np - 1);
				send_item(mk(OP_PROGRAM, b, k, p, $urandom_range(0, 15), $urandom),
					1'b0, ST_OK);
				done++;
			end else if (sel < 85) begin
				// prefer a written page so whole pages come back
				tries = 0;
				do begin
					b = $urandom_range(0, nb - 1);
					k = $urandom_range(0, nk - 1);
					p = $urandom_range(0, np - 1);
					slot = (b * MAX_BLOCKS + k) * MAX_PAGES + p;
					tries++;
				end while (!page_written[slot] && tries < 12);
				send_item(mk(OP_READ, b, k, p, $urandom_range(0, 15), $urandom),
					1'b0, ST_OK);
				done++;
			end else begin
				send_item(mk(OP_ERASE, $urandom_range(0, nb - 1), $urandom_range(0, nk - 1),
					$urandom_range(0, 31), $urandom_range(0, 15), $urandom), 1'b0, ST_OK);
				done++;
			end
		end
	endtask

	always @(posedge clk) begin : beat_check
		beat_t seen;
		beat_t want;
		if (arst_n && m_tvalid && m_tready) begin
			seen = {m_tdata[2:0], m_tdata[34:3], m_tdata[38:35], m_tlast};
			beats_seen++;
			if (beats_due.size() == 0) begin
				$display("%0t: beat with nothing expected: status %0d word %h index %0d last %b",
					$time, seen.status, seen.word, seen.idx, seen.last);
				mismatches++;
			end else begin
				want = beats_due.pop_front();
				if (seen.status !== want.status) begin
					$display("%0t: status expected %0d actual %0d", $time,
						want.status, seen.status);
					mismatches++;
				end
				if (seen.word !== want.word) begin
					$display("%0t: read_word expected %h actual %h", $time,
						want.word, seen.word);
					mismatches++;
				end
				if (seen.idx !== want.idx) begin
					$display("%0t: read_index expected %0d actual %0d", $time,
						want.idx, seen.idx);
					mismatches++;
				end
				if (seen.last !== want.last) begin
					$display("%0t: last expected %b actual %b", $time, want.last, seen.last);
					mismatches++;
				end
			end
		end
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("%0t: timeout with %0d beats still expected", $time, beats_due.size());
			$display("end of test: mismatches");
			$finish;
		end
	end

	// receiver: random stall bursts, one long hold-off when asked
	initial begin : sink
		int n;
		m_tready = 1'b0;
		@(posedge arst_n);
		forever begin
			if (hold_len > 0) begin
				m_tready <= 1'b0;
				n = hold_len;
				hold_len = 0;
				repeat (n) @(posedge clk);
			end else if (!quiet && $urandom_range(0, 4) == 0) begin
				m_tready <= 1'b0;
				repeat ($urandom_range(1, 13)) @(posedge clk);
			end else begin
				m_tready <= 1'b1;
				repeat ($urandom_range(1, 24)) @(posedge clk);
			end
		end
	end

	initial begin : stimulus
		step_t plan [$];
		arst_n   = 1'b0;
		s_tvalid = 1'b0;
		s_tdata  = '0;
		s_tuser  = '0;
		psel     = 1'b0;
		penable  = 1'b0;
		pwrite   = 1'b0;
		paddr    = '0;
		pwdata   = '0;
		foreach (load_buf[i])
			load_buf[i] = 32'd0;
		cfg_banks  = MAX_BANKS;
		cfg_blocks = MAX_BLOCKS;
		cfg_pages  = MAX_PAGES;

		// error paths after reset, buffer extremes, program order, erase
		plan.push_back(plan_row(mk(OP_READ, 0, 0, 0, 0, 0), 1'b1, ST_EMPTY));
		plan.push_back(plan_row(mk(OP_ERASE, 0, 0, 0, 0, 0), 1'b1, ST_EMPTY));
		plan.push_back(plan_row(mk(OP_PROGRAM, 0, 0, 1, 0, 0), 1'b1, ST_POSITION));
		plan.push_back(plan_row(mk(OP_PROGRAM, 3, 31, 31, 15, '1), 1'b1, ST_INVALID));
		plan.push_back(plan_row(mk(OP_READ, 0, 16, 0, 0, 0), 1'b1, ST_INVALID));
		plan.push_back(plan_row(mk(OP_ERASE, 2, 0, 0, 0, 0), 1'b1, ST_INVALID));
		plan.push_back(plan_row(mk(OP_PROGRAM, 0, 0, 16, 0, 0), 1'b1, ST_INVALID));
		plan.push_back(plan_row(mk(OP_LOAD, 3, 31, 31, 0, 32'hffff_ffff), 1'b0, ST_OK));
		plan.push_back(plan_row(mk(OP_LOAD, 0, 0, 0, 1, 32'h0000_0000), 1'b0, ST_OK));
		plan.push_back(plan_row(mk(OP_LOAD, 0, 0, 0, 7, 32'ha5a5_a5a5), 1'b0, ST_OK));
		plan.push_back(plan_row(mk(OP_LOAD, 0, 0, 0, 8, 32'h5a5a_5a5a), 1'b0, ST_OK));
		plan.push_back(plan_row(mk(OP_LOAD, 0, 0, 0, 9, 32'h8000_0001), 1'b0, ST_OK));
		plan.push_back(plan_row(mk(OP_LOAD, 0, 0, 0, 15, 32'hdead_beef), 1'b0, ST_OK));
		plan.push_back(plan_row(mk(OP_LOAD, 0, 0, 0, 10, 32'h1234_5678), 1'b0, ST_OK));
		plan.push_back(plan_row(mk(OP_PROGRAM, 0, 0, 0, 0, 0), 1'b1, ST_OK));
		plan.push_back(plan_row(mk(OP_PROGRAM, 0, 0, 0, 0, 0), 1'b1, ST_OVERWRITE));
		plan.push_back(plan_row(mk(OP_READ, 0, 0, 0, 0, 0), 1'b0, ST_OK));
		plan.push_back(plan_row(mk(OP_PROGRAM, 1, 15, 0, 0, 0), 1'b1, ST_OK));
		plan.push_back(plan_row(mk(OP_PROGRAM, 1, 15, 1, 0, 0), 1'b1, ST_OK));
		plan.push_back(plan_row(mk(OP_READ, 1, 15, 1, 0, 0), 1'b0, ST_OK));
		plan.push_back(plan_row(mk(OP_READ, 1, 15, 15, 0, 0), 1'b1, ST_EMPTY));
		// erase ignores the page field
		plan.push_back(plan_row(mk(OP_ERASE, 1, 15, 31, 0, 0), 1'b1, ST_OK));
		plan.push_back(plan_row(mk(OP_READ, 1, 15, 0, 0, 0), 1'b1, ST_EMPTY));
		plan.push_back(plan_row(mk(OP_ERASE, 1, 15, 0, 0, 0), 1'b1, ST_EMPTY));
		plan.push_back(plan_row(mk(OP_PROGRAM, 1, 15, 0, 0, 0), 1'b0, ST_OK));

		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (plan[i])
			send_item(plan[i].it, plan[i].typed, plan[i].st);

		// smallest sizes, sizes past the maximum, a shrunken page count,
		// all sizes zero, full sizes under a long receiver hold, then quiet
		run_phase(1, 1, 1, 40, 0, 1'b0);
		run_phase(3, 31, 31, 70, 0, 1'b1);
		run_phase(2, 4, 3, 50, 0, 1'b0);
		run_phase(0, 0, 0, 12, 0, 1'b0);
		run_phase(2, 16, 16, 60, 400, 1'b0);
		quiet = 1'b1;
		run_phase(1, 2, 16, 55, 0, 1'b0);

		drain(SETTLE_CYC);
		$display("ran %0d items through %0d size settings, %0d result beats compared",
			items_sent, phases_run, beats_seen);
		$display("covered all operations, address errors, program order and erase rules");
		if (mismatches == 0)
			$display("end of test: clean");
		else
			$display("end of test: mismatches");
		$finish;
	end

endmodule
